>>> hw/rtl/wgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared constants for the glob pattern matcher: item kinds, special
// pattern characters and stream widths.
// ----------------------------------------------------------------------------
package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 128;

	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 16;
	localparam int OUT_W   = 24;   // matched + name_index, padded to bytes

	// item kind carried in tuser
	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_NAME    = 1'b1;

	localparam logic [CHAR_W-1:0] CH_ANY_ONE = 8'h3F;  // '?'
	localparam logic [CHAR_W-1:0] CH_ANY_RUN = 8'h2A;  // '*'

endpackage : wgm_pkg
`default_nettype wire

>>> hw/rtl/wildcard_glob_matcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// Glob matcher ('?' any one char, '*' any run) run as a bit-parallel NFA.
//
// Usage: one input stream s_*, one result stream m_*. A beat with
// tuser = 0 loads a pattern character; tlast closes the pattern. A beat with
// tuser = 1 presents a name character; on the beat with tlast a result beat
// goes out with the match flag and the name's index (counted from the last
// pattern close, wrapping at 65536). Name beats sent while a pattern is open
// are dropped without a result.
// Flow: a beat is held in the input register, then updates the position
// vector; its result lands in the output register at that same edge.
// Throughput: one beat per cycle unless stalled; every pattern position
// (MAX_PATTERN + 1 bits) is updated at once, with a log-depth scan for '*' closure.
// Reset: the pattern is empty and closed, so every name reports no match.
// Stall: with a result waiting, s_tready drops only while the input register
// holds another last name beat; other beats keep flowing.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit
	import wgm_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [CHAR_W-1:0] s_tdata,   // [7:0] char_in
	input  wire logic              s_tuser,   // [0] func
	input  wire logic              s_tlast,
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata    // [0] matched, [16:1] name_index, rest 0
);

	localparam int NP = MAX_PATTERN + 1;                          // positions 0..MAX
	localparam int LW = $clog2(MAX_PATTERN + 1);                  // pattern length
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LV = (NP > 1) ? $clog2(NP) : 1;                // scan levels

	// input register
	logic              v_s1;
	logic              func_s1;
	logic              last_s1;
	logic [CHAR_W-1:0] char_s1;

	// pattern store: each entry read by its own position slice
	logic [CHAR_W-1:0] chr_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] star_q;
	logic [MAX_PATTERN-1:0] any_q;

	logic [LW-1:0]          len_q;
	logic                   closed_q;
	logic [MAX_PATTERN-1:0] en_q;       // position i < len
	logic [NP-1:0]          lead_q;     // start position closed over leading '*'
	logic [NP-1:0]          act_q;
	logic                   restart_q;  // act_q stale, use lead_q
	logic [INDEX_W-1:0]     cnt_q;

	logic                   out_match_q;
	logic [INDEX_W-1:0]     out_idx_q;
	logic                   out_v_q;

	logic                   is_pat, is_name, res_s1, adv;
	logic [LW-1:0]          wr_len;
	logic                   wr_ok;
	logic [IW-1:0]          wr_idx;
	logic                   wr_star;
	logic [NP-1:0]          lead_base, lead_n;
	logic [MAX_PATTERN-1:0] en_base, en_n;
	logic [NP-1:0]          eff, nxt;

	assign is_pat  = v_s1 && (func_s1 == FUNC_PATTERN);
	assign is_name = v_s1 && (func_s1 == FUNC_NAME) && closed_q;
	assign res_s1  = is_name && last_s1;
	assign adv     = !res_s1 || !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv;

	// pattern write: a beat after close starts a fresh pattern
	assign wr_len    = closed_q ? '0 : len_q;
	assign wr_ok     = wr_len < LW'(MAX_PATTERN);
	assign wr_idx    = wr_len[IW-1:0];
	assign wr_star   = (char_s1 == CH_ANY_RUN);
	assign lead_base = closed_q ? NP'(1) : lead_q;
	assign en_base   = closed_q ? '0 : en_q;

	always_comb begin
		lead_n = lead_base;
		en_n   = en_base;
		if (wr_ok) begin
			en_n[wr_idx] = 1'b1;
			lead_n[wr_len + LW'(1)] = lead_base[wr_len] && wr_star;
		end
	end

	assign eff = restart_q ? lead_q : act_q;

	// one character step, then spread through runs of '*'
	always_comb begin
		logic [NP-1:0] g, p, gn, pn;
		int step;
		g = '0;
		p = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (eff[i] && en_q[i]) begin
				if (star_q[i])
					g[i] = 1'b1;
				else if (any_q[i] || chr_q[i] == char_s1)
					g[i+1] = 1'b1;
			end
			p[i+1] = en_q[i] && star_q[i];
		end
		for (int lv = 0; lv < LV; lv++) begin
			step = 1 << lv;
			for (int j = 0; j < NP; j++) begin
				if (j >= step) begin
					gn[j] = g[j] | (p[j] & g[j-step]);
					pn[j] = p[j] & p[j-step];
				end else begin
					gn[j] = g[j];
					pn[j] = p[j];
				end
			end
			g = gn;
			p = pn;
		end
		nxt = g;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			last_s1 <= s_tlast;
			char_s1 <= s_tdata;
		end
		if (is_pat && wr_ok) begin
			chr_q[wr_idx]  <= char_s1;
			star_q[wr_idx] <= wr_star;
			any_q[wr_idx]  <= (char_s1 == CH_ANY_ONE);
		end
		if (res_s1 && adv) begin
			out_match_q <= nxt[len_q];
			out_idx_q   <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			closed_q  <= 1'b1;
			en_q      <= '0;
			lead_q    <= NP'(1);
			act_q     <= NP'(1);
			restart_q <= 1'b1;
			cnt_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (is_pat) begin
				closed_q <= last_s1;
				en_q     <= en_n;
				lead_q   <= lead_n;
				if (wr_ok)
					len_q <= wr_len + LW'(1);
				else
					len_q <= wr_len;
				if (last_s1) begin
					cnt_q     <= '0;
					restart_q <= 1'b1;
				end
			end else if (is_name && adv) begin
				act_q     <= nxt;
				restart_q <= last_s1;
				if (last_s1)
					cnt_q <= cnt_q + INDEX_W'(1);
			end
			if (res_s1 && adv)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(OUT_W - INDEX_W - 1){1'b0}}, out_idx_q, out_match_q};

	// live positions never run past the stored pattern
	a_act_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(closed_q && !restart_q) |-> ((act_q & ~{en_q, 1'b1}) == '0))
		else $error("active position beyond pattern length");

	a_lead_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lead_q[0] && ((lead_q & ~{en_q, 1'b1}) == '0)))
		else $error("start vector inconsistent with pattern length");

	// input side only waits on a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && res_s1))
		else $error("input stalled without a blocked result");

endmodule : wildcard_glob_matcher_unit
`default_nettype wire
